// ===== rtl/pra_pkg.sv =====
// Shared types and constants for the page allocator with reference counts.
// Used by the top level and the port checker; depends on nothing else.
`timescale 1ns / 1ps

package pra_pkg;

  // Fixed field widths of the stream beats
  localparam int ADDR_W  = 28;
  localparam int CNT_W   = 16;
  localparam int FREE_W  = 17;
  localparam int LOW_W   = 16;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 64;

  // Defaults for the top-level parameters
  localparam int NUM_PAGES_DEF  = 65536;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_ADD   = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_OOM = 2'd2
  } status_t;

  // Result beat, status in the lowest bits
  typedef struct packed {
    logic [FREE_W-1:0] free_pages;
    logic [CNT_W-1:0]  use_count;
    logic [ADDR_W-1:0] page_addr;
    status_t           status;
  } out_beat_t;

endpackage

// ===== rtl/pra_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the free-page stack and the reference-count table; no package needed.
`timescale 1ns / 1ps

module pra_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/page_allocator_refcount.sv =====
// Page frame allocator: LIFO free-page stack plus per-page reference counts.
// Depends on pra_pkg and pra_ram (stack memory and count table).
//
//   channel   dir  beat fields (low bit up)
//   in_*      in   func[1:0], phys_addr[29:2]
//   out_*     out  status[1:0], page_addr[29:2], use_count[45:30], free_pages[62:46]
//   cfg_*     in   lowest_page[15:0], written on cfg_wen
//
// Free, add-reference and query read the count table first; then they modify,
// write back and load the output register in the execute state.
// Allocate reads the stack first: its read gives the page, which then addresses
// the count table. The next beat is taken once the write-back is done.
// After reset a clearing pass zeroes every entry of the count table, with
// in_tready low. A result waiting on out_tready holds the item in its write
// stage; one new beat can still be taken while the output register is full.
`timescale 1ns / 1ps

module page_allocator_refcount #(
  parameter int NUM_PAGES  = pra_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = pra_pkg::PAGE_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // func[1:0], phys_addr[29:2], zero pad [31:30]
  input  logic [pra_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // status[1:0], page_addr[29:2], use_count[45:30], free_pages[62:46], pad [63]
  output logic [pra_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_wen,
  input  logic [pra_pkg::LOW_W-1:0]  cfg_wdata
);

  import pra_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int DW  = $clog2(NUM_PAGES + 1);
  localparam int PGW = ADDR_W - PAGE_SHIFT;
  localparam int EW  = PW + PAGE_SHIFT;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_EXEC
  } state_t;

  state_t            state_r;
  logic [PW-1:0]     clr_idx_r;
  logic [DW-1:0]     depth_r;
  logic [DW-1:0]     depth_nxt;
  logic [LOW_W-1:0]  lowest_r;
  func_t             func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PW-1:0]     page_r;
  logic              out_valid_r;
  out_beat_t         out_beat_r;
  out_beat_t         beat_nxt;

  // Input beat fields
  func_t             in_func;
  logic [ADDR_W-1:0] in_addr;
  logic [PW-1:0]     in_idx;
  logic              in_fire;

  // Memory ports
  logic              ref_we;
  logic [PW-1:0]     ref_waddr;
  logic [CNT_W-1:0]  ref_wdata;
  logic [PW-1:0]     ref_raddr;
  logic [CNT_W-1:0]  ref_rdata;
  logic              stk_we;
  logic [PW-1:0]     stk_waddr;
  logic [PW-1:0]     stk_rdata;
  logic [DW-1:0]     depth_dec;
  logic [PW-1:0]     stk_raddr;

  // Item decode
  logic [PGW-1:0]    page_full;
  logic              in_range;
  logic              offset_nz;
  logic              below_floor;
  logic [ADDR_W-1:0] paddr;
  logic [EW-1:0]     alloc_wide;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic              out_free;
  logic              done;

  assign in_func   = func_t'(in_tdata[1:0]);
  assign in_addr   = in_tdata[ADDR_W+1:2];
  assign in_idx    = PW'(in_addr[ADDR_W-1:PAGE_SHIFT]);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_free  = !out_valid_r || out_tready;
  assign done      = (state_r == S_EXEC) && out_free;

  // Stack top address and count-table read address
  assign depth_dec = depth_r - 1'b1;
  assign stk_raddr = depth_dec[PW-1:0];

  always_comb begin
    unique case (state_r)
      S_IDLE:  ref_raddr = in_idx;
      S_POP:   ref_raddr = stk_rdata;
      default: ref_raddr = page_r;
    endcase
  end

  // Decode the held address
  assign page_full   = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign in_range    = 32'(page_full) < 32'(NUM_PAGES);
  assign offset_nz   = |addr_r[PAGE_SHIFT-1:0];
  assign below_floor = 32'(page_full) < 32'(lowest_r);
  assign paddr       = {page_full, {PAGE_SHIFT{1'b0}}};
  assign alloc_wide  = {page_r, {PAGE_SHIFT{1'b0}}};
  assign cnt_inc     = (ref_rdata == CNT_MAX) ? ref_rdata : ref_rdata + 1'b1;
  assign cnt_dec     = (ref_rdata == '0) ? ref_rdata : ref_rdata - 1'b1;

  // Modify step: result beat, write-back and new stack depth
  always_comb begin
    ref_we               = 1'b0;
    ref_waddr            = page_r;
    ref_wdata            = '0;
    stk_we               = 1'b0;
    stk_waddr            = depth_r[PW-1:0];
    depth_nxt            = depth_r;
    beat_nxt.status      = ST_OK;
    beat_nxt.page_addr   = paddr;
    beat_nxt.use_count   = ref_rdata;
    unique case (func_r)
      FN_ALLOC: begin
        if (depth_r == '0) begin
          beat_nxt.status    = ST_OOM;
          beat_nxt.page_addr = '0;
          beat_nxt.use_count = '0;
        end else begin
          depth_nxt          = depth_dec;
          ref_we             = done;
          ref_wdata          = cnt_inc;
          beat_nxt.page_addr = ADDR_W'(alloc_wide);
          beat_nxt.use_count = cnt_inc;
        end
      end
      FN_FREE: begin
        if (!in_range) begin
          beat_nxt.status    = ST_BAD;
          beat_nxt.use_count = '0;
        end else if (offset_nz || below_floor) begin
          beat_nxt.status    = ST_BAD;
        end else begin
          ref_we             = done;
          ref_wdata          = cnt_dec;
          beat_nxt.use_count = cnt_dec;
          if (cnt_dec == '0) begin
            if (depth_r >= DW'(NUM_PAGES)) begin
              beat_nxt.status = ST_BAD;
            end else begin
              stk_we    = done;
              depth_nxt = depth_r + 1'b1;
            end
          end
        end
      end
      FN_ADD: begin
        if (!in_range) begin
          beat_nxt.status    = ST_BAD;
          beat_nxt.use_count = '0;
        end else begin
          ref_we             = done;
          ref_wdata          = cnt_inc;
          beat_nxt.use_count = cnt_inc;
        end
      end
      FN_QUERY: begin
        if (!in_range) begin
          beat_nxt.status    = ST_BAD;
          beat_nxt.use_count = '0;
        end
      end
    endcase
    beat_nxt.free_pages = FREE_W'(depth_nxt);
    // Clearing pass owns the table write port
    if (state_r == S_CLEAR) begin
      ref_we    = 1'b1;
      ref_waddr = clr_idx_r;
      ref_wdata = '0;
    end
  end

  // Sequencer, stack depth, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      depth_r     <= '0;
      lowest_r    <= '0;
      func_r      <= FN_QUERY;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        lowest_r <= cfg_wdata;
      end
      // Drop the result beat once taken, unless a new one loads now
      if (out_valid_r && out_tready && !done) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == PW'(NUM_PAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            func_r  <= in_func;
            addr_r  <= in_addr;
            page_r  <= in_idx;
            state_r <= (in_func == FN_ALLOC) ? S_POP : S_EXEC;
          end
        end
        S_POP: begin
          page_r  <= stk_rdata;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (done) begin
            depth_r     <= depth_nxt;
            out_beat_r  <= beat_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_beat_r);

  // Free-page stack
  pra_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (page_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Reference-count table
  pra_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (CNT_W)
  ) u_ref (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

endmodule

// ===== rtl/pra_checker.sv =====
// Port-level checks for the page allocator, bound to the top level.
// Depends on pra_pkg for field widths and status codes.
`timescale 1ns / 1ps

module pra_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [pra_pkg::OUT_W-1:0]  out_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready
);

  import pra_pkg::*;

  out_beat_t beat;
  assign beat = out_beat_t'(out_tdata[$bits(out_beat_t)-1:0]);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Only one item is in flight at a time: accepting a beat drops in_tready
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while an item is in flight");

  // Out of memory reports an empty stack, no page and no count
  a_oom_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && beat.status == ST_OOM |->
      beat.page_addr == '0 && beat.use_count == '0 && beat.free_pages == '0)
    else $error("out-of-memory beat with nonzero fields");

endmodule

bind page_allocator_refcount pra_checker u_pra_checker (.*);

// ===== test/page_allocator_refcount_tb.sv =====
// Self-checking testbench for the page allocator with reference counts.
// Drives beats on the input stream, predicts every result beat from its own
// allocator model and compares them in order; depends on pra_pkg and the RTL.
`timescale 1ns / 1ps

module page_allocator_refcount_tb;
  import pra_pkg::*;

  localparam int NUM_PAGES  = NUM_PAGES_DEF;
  localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
  localparam int MAX_SHOWN  = 10;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic [IN_W-1:0]     in_tdata   = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_wen    = 1'b0;
  logic [LOW_W-1:0]    cfg_wdata  = '0;

  // Allocator model state
  logic [15:0]         free_list [NUM_PAGES];
  logic [CNT_W-1:0]    page_refs [NUM_PAGES];
  int unsigned         free_top;
  int unsigned         floor_page;

  out_beat_t           pending_results [$];
  int unsigned         live_pages [$];
  bit                  idle_on;
  int                  stall_left;
  int                  mismatches;

  page_allocator_refcount #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] page_base(int unsigned pg);
    return ADDR_W'(pg << PAGE_SHIFT);
  endfunction

  // Apply one operation to the model and return the result beat it gives
  function automatic out_beat_t alloc_outcome(func_t fn, logic [ADDR_W-1:0] addr);
    out_beat_t   r;
    int unsigned pg;
    int unsigned popped;
    pg          = addr >> PAGE_SHIFT;
    r.status    = ST_OK;
    r.page_addr = page_base(pg);
    r.use_count = '0;
    if (fn == FN_ALLOC) begin
      if (free_top == 0) begin
        r.status    = ST_OOM;
        r.page_addr = '0;
      end else begin
        free_top = free_top - 1;
        popped   = free_list[free_top] % NUM_PAGES;
        if (page_refs[popped] != CNT_MAX) page_refs[popped] = page_refs[popped] + 1;
        r.page_addr = page_base(popped);
        r.use_count = page_refs[popped];
      end
    end else if (pg >= NUM_PAGES) begin
      // page beyond memory: reject, count reads as zero
      r.status = ST_BAD;
    end else if (fn == FN_FREE) begin
      if (addr[PAGE_SHIFT-1:0] != 0 || pg < floor_page) begin
        r.status    = ST_BAD;
        r.use_count = page_refs[pg];
      end else begin
        if (page_refs[pg] != 0) page_refs[pg] = page_refs[pg] - 1;
        r.use_count = page_refs[pg];
        if (page_refs[pg] == 0) begin
          // last reference gone: push unless the stack is already full
          if (free_top >= NUM_PAGES) begin
            r.status = ST_BAD;
          end else begin
            free_list[free_top] = pg[15:0];
            free_top = free_top + 1;
          end
        end
      end
    end else begin
      if (fn == FN_ADD && page_refs[pg] != CNT_MAX) page_refs[pg] = page_refs[pg] + 1;
      r.use_count = page_refs[pg];
    end
    r.free_pages = FREE_W'(free_top);
    return r;
  endfunction

  // Send one request beat, then log what it should produce
  task automatic send_item(func_t fn, logic [ADDR_W-1:0] addr);
    int        gap;
    out_beat_t want;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, addr, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = alloc_outcome(fn, addr);
    pending_results.push_back(want);
    if (fn == FN_ALLOC && want.status == ST_OK) begin
      live_pages.push_back(want.page_addr >> PAGE_SHIFT);
      if (live_pages.size() > 48) void'(live_pages.pop_front());
    end
  endtask

  // Drop valid and hold until every outstanding result has been seen
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_floor(int unsigned value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= LOW_W'(value);
    @(posedge clk);
    cfg_wen    <= 1'b0;
    floor_page = value;
  endtask

  task automatic check_result(logic [OUT_W-1:0] beat);
    out_beat_t got;
    out_beat_t want;
    got = beat[$bits(out_beat_t)-1:0];
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: result beat with nothing outstanding: %h", $time, beat);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.page_addr !== want.page_addr ||
          got.use_count !== want.use_count || got.free_pages !== want.free_pages) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: exp st=%0d addr=%h cnt=%0d free=%0d, got st=%0d addr=%h cnt=%0d free=%0d",
                   $time, want.status, want.page_addr, want.use_count, want.free_pages,
                   got.status, got.page_addr, got.use_count, got.free_pages);
      end
    end
  endtask

  // Result side: take beats, check them, stall at random after each one while idle_on is set
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
        stall_left = idle_on ? $urandom_range(0, 19) : 0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_tready <= (stall_left == 0);
    end
  end

  task automatic test_empty_alloc();
    send_item(FN_ALLOC, '0);
    send_item(FN_ALLOC, {ADDR_W{1'b1}});
    send_item(FN_QUERY, '0);
  endtask

  task automatic test_add_query();
    // offset bits are ignored on add and query
    send_item(FN_ADD, {ADDR_W{1'b1}});
    send_item(FN_QUERY, page_base(NUM_PAGES - 1));
    send_item(FN_QUERY, page_base(5) | 28'h7FF);
  endtask

  task automatic test_free_alloc();
    send_item(FN_FREE, page_base(10));
    send_item(FN_FREE, page_base(20));
    send_item(FN_ALLOC, '0);
    send_item(FN_ALLOC, '0);
    send_item(FN_ALLOC, '0);
    send_item(FN_FREE, page_base(20));
    // raise the count of a page still on the stack, then pop it
    send_item(FN_ADD, page_base(20));
    send_item(FN_ALLOC, '0);
    send_item(FN_FREE, page_base(20));
    send_item(FN_FREE, page_base(20));
  endtask

  task automatic test_bad_free();
    send_item(FN_FREE, page_base(10) | 28'h001);
    send_item(FN_FREE, {ADDR_W{1'b1}});
    send_item(FN_FREE, page_base(12'h800) | 28'h800);
  endtask

  task automatic test_floor();
    set_floor(16);
    send_item(FN_FREE, page_base(15));
    send_item(FN_FREE, page_base(16));
    set_floor(16'hFFFF);
    send_item(FN_FREE, page_base(16'hFFFE));
    send_item(FN_FREE, page_base(16'hFFFF));
    set_floor(0);
    send_item(FN_FREE, '0);
  endtask

  task automatic random_mix(int count);
    int unsigned        sel;
    int unsigned        pick;
    int unsigned        pg;
    func_t              fn;
    logic [ADDR_W-1:0]  addr;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)      fn = FN_ALLOC;
      else if (sel < 60) fn = FN_FREE;
      else if (sel < 80) fn = FN_ADD;
      else               fn = FN_QUERY;
      // mostly pages in use, some fresh pages above the floor, a few anywhere
      pick = $urandom_range(0, 99);
      if (live_pages.size() > 0 && pick < 60)
        pg = live_pages[$urandom_range(0, live_pages.size() - 1)];
      else if (pick < 85)
        pg = $urandom_range(floor_page, NUM_PAGES - 1);
      else
        pg = $urandom_range(0, NUM_PAGES - 1);
      addr = page_base(pg);
      if (fn == FN_FREE) begin
        if ($urandom_range(0, 9) == 0) addr = addr | ADDR_W'($urandom_range(1, 4095));
      end else if ($urandom_range(0, 1) == 1) begin
        addr = addr | ADDR_W'($urandom_range(0, 4095));
      end
      if ($urandom_range(0, 19) == 0) addr = ADDR_W'($urandom());
      send_item(fn, addr);
    end
  endtask

  task automatic test_random();
    set_floor($urandom_range(1, 64));
    random_mix(100);
    set_floor($urandom_range(0, 16'hFFFF));
    random_mix(100);
    idle_on = 1'b0;
    set_floor(0);
    random_mix(100);
    idle_on = 1'b1;
    set_floor(16'hFFFF);
    random_mix(60);
    set_floor(0);
    random_mix(140);
  endtask

  initial begin
    int waited;
    foreach (page_refs[i]) page_refs[i] = '0;
    free_top   = 0;
    floor_page = 0;
    mismatches = 0;
    stall_left = 0;
    idle_on    = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_alloc();
    test_add_query();
    test_free_alloc();
    test_bad_free();
    test_floor();
    test_random();

    // drain the last results, bounded
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() > 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches = mismatches + pending_results.size();
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pra_pkg.sv
rtl/pra_ram.sv
rtl/page_allocator_refcount.sv
rtl/pra_checker.sv
test/page_allocator_refcount_tb.sv
